[rtl/rectangle_raster_painter_core_macros.svh]
// Assertion helpers used by the core RTL file.
`ifndef RECTANGLE_RASTER_PAINTER_CORE_MACROS_SVH
`define RECTANGLE_RASTER_PAINTER_CORE_MACROS_SVH

`ifndef SYNTH
`define RRP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rectangle raster painter check failed");
`define RRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rectangle raster painter check failed");
`else
`define RRP_ASSERT_SAME(label, ante, cons)
`define RRP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/rrp_pkg.sv]
package rrp_pkg;

    localparam int MAX_SIDE = 256;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int CFG_W    = SIDE_W + 1;
    localparam int COLOR_W  = 8;
    localparam int POS_W    = 24;
    localparam int SIZE_W   = 23;
    localparam int FRAC_W   = 8;
    // Edge plus size plus one unit of margin, signed.
    localparam int COORD_W  = 26;

    localparam logic signed [COORD_W-1:0] ONE_UNIT = COORD_W'(1 << FRAC_W);

    localparam logic [1:0] CFG_BOARD_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_BOARD_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND_COLOR = 2'd2;

    localparam logic [CFG_W-1:0]   RESET_WIDTH      = CFG_W'(256);
    localparam logic [CFG_W-1:0]   RESET_HEIGHT     = CFG_W'(256);
    localparam logic [COLOR_W-1:0] RESET_BACKGROUND = COLOR_W'(32);

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ZERO_SIZE = 2'd1,
        STATUS_RANGE     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_FETCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] left_in;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] right_in;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] top_in;
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] bottom_in;
    } rrp_bounds_t;

    typedef struct packed {
        logic in_rect;
        logic outline;
    } rrp_cover_t;

    // Index of the last column or row in use; out-of-range sizes are clamped.
    function automatic logic [SIDE_W-1:0] last_index(input logic [CFG_W-1:0] side);
        logic [SIDE_W-1:0] r;
        if (side == '0)
            r = '0;
        else if (side > CFG_W'(MAX_SIDE))
            r = SIDE_W'(MAX_SIDE - 1);
        else
            r = SIDE_W'(side - CFG_W'(1));
        return r;
    endfunction

endpackage

[rtl/rrp_ram.sv]
module rrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/rrp_pixel_test.sv]
module rrp_pixel_test (
    input  rrp_pkg::rrp_bounds_t        bounds,
    input  logic [rrp_pkg::SIDE_W-1:0]  col,
    input  logic [rrp_pkg::SIDE_W-1:0]  row,
    output rrp_pkg::rrp_cover_t         pixel_class
);
    import rrp_pkg::*;

    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      in_rect;
    logic                      near_edge;

    // A pixel center sits at its integer position in the 8-fraction-bit grid.
    assign px = $signed({{(COORD_W - SIDE_W - FRAC_W){1'b0}}, col, {FRAC_W{1'b0}}});
    assign py = $signed({{(COORD_W - SIDE_W - FRAC_W){1'b0}}, row, {FRAC_W{1'b0}}});

    assign in_rect = (px >= bounds.left) && (px <= bounds.right) &&
                     (py >= bounds.top) && (py <= bounds.bottom);

    assign near_edge = (px < bounds.left_in) || (px > bounds.right_in) ||
                       (py < bounds.top_in) || (py > bounds.bottom_in);

    assign pixel_class.in_rect = in_rect;
    assign pixel_class.outline = in_rect && near_edge;

endmodule

[rtl/rectangle_raster_painter_core.sv]
// Clear and draw walk the in-use frame at one pixel per cycle through one frame RAM
// write port. Read makes one registered RAM read; a rejected draw or a read outside the
// frame goes straight from dispatch to the result. One item is in work at a time; the
// next item is taken the cycle after the result is loaded into the output register.
// Reset sets the size registers to 256 and the background to 32; frame contents are
// undefined until the first clear.
`include "rectangle_raster_painter_core_macros.svh"

module rectangle_raster_painter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [rrp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic                          filled,
    input  logic signed [rrp_pkg::POS_W-1:0] rect_x,
    input  logic signed [rrp_pkg::POS_W-1:0] rect_y,
    input  logic [rrp_pkg::SIZE_W-1:0]    rect_w,
    input  logic [rrp_pkg::SIZE_W-1:0]    rect_h,
    input  logic [rrp_pkg::COLOR_W-1:0]   paint_color,
    input  logic [rrp_pkg::SIDE_W-1:0]    read_col,
    input  logic [rrp_pkg::SIDE_W-1:0]    read_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rrp_pkg::COLOR_W-1:0]   pixel,
    output logic [1:0]                    status
);
    import rrp_pkg::*;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [COLOR_W-1:0] bg_reg;

    logic [1:0]         func_reg, func_next;
    logic               filled_reg, filled_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [SIDE_W-1:0]  rcol_reg, rcol_next;
    logic [SIDE_W-1:0]  rrow_reg, rrow_next;
    logic               zero_reg, zero_next;
    rrp_bounds_t        bounds_reg, bounds_next;

    logic [SIDE_W-1:0]  col_reg, col_next;
    logic [SIDE_W-1:0]  row_reg, row_next;

    logic [COLOR_W-1:0] res_pixel_reg, res_pixel_next;
    logic [1:0]         res_status_reg, res_status_next;

    logic               out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] pixel_reg, pixel_next;
    logic [1:0]         status_reg, status_next;

    logic [SIDE_W-1:0]  last_col;
    logic [SIDE_W-1:0]  last_row;
    logic               last_pixel;
    logic               slot_free;
    logic               in_accept;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [COLOR_W-1:0] ram_rdata;

    rrp_cover_t         pixel_class;

    logic signed [COORD_W-1:0] x_ext, y_ext;
    logic signed [COORD_W-1:0] w_ext, h_ext;

    assign last_col   = last_index(width_reg);
    assign last_row   = last_index(height_reg);
    assign last_pixel = (col_reg == last_col) && (row_reg == last_row);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign status    = status_reg;

    assign x_ext = COORD_W'(rect_x);
    assign y_ext = COORD_W'(rect_y);
    assign w_ext = $signed({{(COORD_W - SIZE_W){1'b0}}, rect_w});
    assign h_ext = $signed({{(COORD_W - SIZE_W){1'b0}}, rect_h});

    rrp_pixel_test u_pixel_test (
        .bounds      (bounds_reg),
        .col         (col_reg),
        .row         (row_reg),
        .pixel_class (pixel_class)
    );

    rrp_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr = {row_reg, col_reg};
    assign ram_raddr = {rrow_reg, rcol_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = color_reg;
        if (state_reg == ST_SCAN)
        begin
            if (func_reg == FUNC_CLEAR)
            begin
                ram_we    = 1'b1;
                ram_wdata = bg_reg;
            end
            else
            begin
                ram_we = filled_reg ? pixel_class.in_rect : pixel_class.outline;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            bg_reg     <= RESET_BACKGROUND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOARD_WIDTH:      width_reg  <= cfg_wdata;
                CFG_BOARD_HEIGHT:     height_reg <= cfg_wdata;
                CFG_BACKGROUND_COLOR: bg_reg     <= cfg_wdata[COLOR_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        filled_reg     <= filled_next;
        color_reg      <= color_next;
        rcol_reg       <= rcol_next;
        rrow_reg       <= rrow_next;
        zero_reg       <= zero_next;
        bounds_reg     <= bounds_next;
        res_pixel_reg  <= res_pixel_next;
        res_status_reg <= res_status_next;
        pixel_reg      <= pixel_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        filled_next     = filled_reg;
        color_next      = color_reg;
        rcol_next       = rcol_reg;
        rrow_next       = rrow_reg;
        zero_next       = zero_reg;
        bounds_next     = bounds_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        res_pixel_next  = res_pixel_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pixel_next      = pixel_reg;
        status_next     = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next    = func;
                    filled_next  = filled;
                    color_next   = paint_color;
                    rcol_next    = read_col;
                    rrow_next    = read_row;
                    zero_next    = (rect_w == '0) || (rect_h == '0);
                    bounds_next.left      = x_ext;
                    bounds_next.left_in   = x_ext + ONE_UNIT;
                    bounds_next.right     = x_ext + w_ext;
                    bounds_next.right_in  = x_ext + w_ext - ONE_UNIT;
                    bounds_next.top       = y_ext;
                    bounds_next.top_in    = y_ext + ONE_UNIT;
                    bounds_next.bottom    = y_ext + h_ext;
                    bounds_next.bottom_in = y_ext + h_ext - ONE_UNIT;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                res_pixel_next  = '0;
                res_status_next = STATUS_OK;
                col_next        = '0;
                row_next        = '0;
                state_next      = ST_FINISH;
                case (func_reg)
                    FUNC_CLEAR:
                    begin
                        state_next = ST_SCAN;
                    end
                    FUNC_DRAW:
                    begin
                        if (zero_reg)
                            res_status_next = STATUS_ZERO_SIZE;
                        else
                            state_next = ST_SCAN;
                    end
                    FUNC_READ:
                    begin
                        if ((rcol_reg > last_col) || (rrow_reg > last_row))
                            res_status_next = STATUS_RANGE;
                        else
                            state_next = ST_FETCH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (last_pixel)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = ST_FINISH;
                end
                else if (col_reg == last_col)
                begin
                    col_next = '0;
                    row_next = row_reg + SIDE_W'(1);
                end
                else
                begin
                    col_next = col_reg + SIDE_W'(1);
                end
            end
            ST_FETCH:
            begin
                // The RAM read address has been steady since the item was taken.
                res_pixel_next = ram_rdata;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = res_pixel_reg;
                    status_next    = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RRP_ASSERT_SAME(a_write_only_in_scan, ram_we, state_reg == ST_SCAN)
    `RRP_ASSERT_NEXT(a_scan_returns_to_zero, (state_reg == ST_SCAN) && last_pixel,
        (state_reg == ST_FINISH) && (col_reg == '0) && (row_reg == '0))
    `RRP_ASSERT_NEXT(a_finish_loads_output, (state_reg == ST_FINISH) && slot_free,
        out_valid_reg && (state_reg == ST_IDLE))
    `RRP_ASSERT_SAME(a_range_has_zero_pixel, out_valid_reg && (status_reg == STATUS_RANGE),
        pixel_reg == '0)
    `RRP_ASSERT_SAME(a_scan_in_bounds, state_reg == ST_SCAN,
        (col_reg <= last_col) && (row_reg <= last_row))

endmodule

[tb/sv/tb_canvas_pkg.sv]
`timescale 1ns / 100ps
package tb_canvas_pkg;

    import rrp_pkg::*;

    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam longint     UNIT         = longint'(1) << FRAC_W;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        status_t            status;
    } readback_t;

    class canvas_model;

        bit [COLOR_W-1:0]   frame_mem [DEPTH];
        logic [CFG_W-1:0]   width_reg  = RESET_WIDTH;
        logic [CFG_W-1:0]   height_reg = RESET_HEIGHT;
        logic [COLOR_W-1:0] backdrop   = RESET_BACKGROUND;
        readback_t          expected_readbacks[$];
        int                 errors = 0;

        // Size registers outside 1..MAX_SIDE are clamped by the block.
        function int unsigned side_in_use(logic [CFG_W-1:0] side);
            if (side == '0)
                return 1;
            if (side > MAX_SIDE)
                return MAX_SIDE;
            return 32'(side);
        endfunction

        function int unsigned cols_in_use();
            return side_in_use(width_reg);
        endfunction

        function int unsigned rows_in_use();
            return side_in_use(height_reg);
        endfunction

        function int pending();
            return expected_readbacks.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_BOARD_WIDTH:      width_reg = val;
                CFG_BOARD_HEIGHT:     height_reg = val;
                CFG_BACKGROUND_COLOR: backdrop = val[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_command(logic [1:0] op, logic fill,
                                   logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                   logic [SIZE_W-1:0] sw, logic [SIZE_W-1:0] sh,
                                   logic [COLOR_W-1:0] color,
                                   logic [SIDE_W-1:0] col, logic [SIDE_W-1:0] row);
            int unsigned cols;
            int unsigned rows;
            longint      left;
            longint      right;
            longint      top;
            longint      bottom;
            longint      px;
            longint      py;
            bit          near_border;
            readback_t   res;
            cols = cols_in_use();
            rows = rows_in_use();
            res.pixel  = '0;
            res.status = STATUS_OK;
            case (op)
                FUNC_CLEAR:
                begin
                    for (int r = 0; r < rows; r++)
                        for (int c = 0; c < cols; c++)
                            frame_mem[r * MAX_SIDE + c] = backdrop;
                end
                FUNC_DRAW:
                begin
                    if (sw == '0 || sh == '0)
                        res.status = STATUS_ZERO_SIZE;
                    else
                    begin
                        left   = longint'(x);
                        top    = longint'(y);
                        right  = left + longint'(sw);
                        bottom = top + longint'(sh);
                        for (int r = 0; r < rows; r++)
                        begin
                            for (int c = 0; c < cols; c++)
                            begin
                                px = longint'(c) * UNIT;
                                py = longint'(r) * UNIT;
                                if (px >= left && px <= right && py >= top && py <= bottom)
                                begin
                                    // Closer than one unit to any side makes the outline.
                                    near_border = (px - left < UNIT) || (right - px < UNIT) ||
                                                  (py - top < UNIT) || (bottom - py < UNIT);
                                    if (fill || near_border)
                                        frame_mem[r * MAX_SIDE + c] = color;
                                end
                            end
                        end
                    end
                end
                FUNC_READ:
                begin
                    if (col >= cols || row >= rows)
                        res.status = STATUS_RANGE;
                    else
                        res.pixel = frame_mem[row * MAX_SIDE + col];
                end
                default: ;
            endcase
            expected_readbacks.push_back(res);
        endfunction

        function void check_readback(logic [COLOR_W-1:0] pix, logic [1:0] st);
            readback_t exp_rb;
            if (expected_readbacks.size() == 0)
            begin
                $error("result with nothing outstanding: pixel %0d status %0d", pix, st);
                errors++;
                return;
            end
            exp_rb = expected_readbacks.pop_front();
            if (pix !== exp_rb.pixel)
            begin
                $error("pixel: expected %0d, actual %0d", exp_rb.pixel, pix);
                errors++;
            end
            if (st !== exp_rb.status)
            begin
                $error("status: expected %0d, actual %0d", exp_rb.status, st);
                errors++;
            end
        endfunction

    endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

    import rrp_pkg::*;
    import tb_canvas_pkg::*;

    localparam int HOLD_AT       = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES = 8;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [CFG_W-1:0]          cfg_wdata;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                func;
    logic                      filled;
    logic signed [POS_W-1:0]   rect_x;
    logic signed [POS_W-1:0]   rect_y;
    logic [SIZE_W-1:0]         rect_w;
    logic [SIZE_W-1:0]         rect_h;
    logic [COLOR_W-1:0]        paint_color;
    logic [SIDE_W-1:0]         read_col;
    logic [SIDE_W-1:0]         read_row;
    logic                      out_valid;
    logic                      out_stall;
    logic [COLOR_W-1:0]        pixel;
    logic [1:0]                status;

    canvas_model model = new();
    int          items_taken = 0;
    bit          burst_mode = 1'b0;
    bit          hold_done = 1'b0;

    rectangle_raster_painter_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid && in_stall === 1'b0)
        begin
            model.take_command(func, filled, rect_x, rect_y, rect_w, rect_h,
                               paint_color, read_col, read_row);
            items_taken <= items_taken + 1;
        end
        if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
            model.check_readback(pixel, status);
    end

    task automatic issue_command(input logic [1:0] op, input logic fill,
                                 input logic signed [POS_W-1:0] x,
                                 input logic signed [POS_W-1:0] y,
                                 input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                                 input logic [COLOR_W-1:0] color,
                                 input logic [SIDE_W-1:0] col, input logic [SIDE_W-1:0] row);
        int unsigned pick;
        int unsigned gap;
        func        <= op;
        filled      <= fill;
        rect_x      <= x;
        rect_y      <= y;
        rect_w      <= sw;
        rect_h      <= sh;
        paint_color <= color;
        read_col    <= col;
        read_row    <= row;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 50)
            gap = 0;
        else if (pick < 85)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        model.set_register(idx, val);
    endtask

    // The extra edge first lets the monitor log an item taken at the current edge.
    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_items(input int count);
        int unsigned             cols;
        int unsigned             rows;
        int unsigned             pick;
        logic [1:0]              op;
        logic                    fill;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SIZE_W-1:0]       sw;
        logic [SIZE_W-1:0]       sh;
        logic [COLOR_W-1:0]      color;
        logic [SIDE_W-1:0]       col;
        logic [SIDE_W-1:0]       row;
        for (int i = 0; i < count; i++)
        begin
            cols  = model.cols_in_use();
            rows  = model.rows_in_use();
            fill  = 1'($urandom());
            x     = POS_W'($urandom());
            y     = POS_W'($urandom());
            sw    = SIZE_W'($urandom());
            sh    = SIZE_W'($urandom());
            color = COLOR_W'($urandom());
            col   = SIDE_W'($urandom());
            row   = SIDE_W'($urandom());
            pick  = $urandom_range(0, 99);
            if (pick < 10)
                op = FUNC_CLEAR;
            else if (pick < 55)
            begin
                op   = FUNC_DRAW;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    // Rectangles around the frame, a few units beyond it on each side.
                    x  = POS_W'(int'($urandom_range(0, (cols + 6) * 256)) - 768);
                    y  = POS_W'(int'($urandom_range(0, (rows + 6) * 256)) - 768);
                    sw = SIZE_W'($urandom_range(1, (cols + 4) * 256));
                    sh = SIZE_W'($urandom_range(1, (rows + 4) * 256));
                    if ($urandom_range(0, 2) == 0)
                    begin
                        x[FRAC_W-1:0] = '0;
                        y[FRAC_W-1:0] = '0;
                        sw = SIZE_W'($urandom_range(1, cols + 4) * 256);
                        sh = SIZE_W'($urandom_range(1, rows + 4) * 256);
                    end
                end
                else if (pick >= 95)
                    sh = '0;
                else if (pick >= 90)
                    sw = '0;
            end
            else if (pick < 92)
            begin
                op = FUNC_READ;
                if ($urandom_range(0, 9) < 8 || (cols == MAX_SIDE && rows == MAX_SIDE))
                begin
                    col = SIDE_W'($urandom_range(0, cols - 1));
                    row = SIDE_W'($urandom_range(0, rows - 1));
                end
                else if (cols < MAX_SIDE && (rows == MAX_SIDE || $urandom_range(0, 1) == 1))
                    col = SIDE_W'($urandom_range(cols, MAX_SIDE - 1));
                else
                    row = SIDE_W'($urandom_range(rows, MAX_SIDE - 1));
            end
            else
                op = FUNC_UNKNOWN;
            issue_command(op, fill, x, y, sw, sh, color, col, row);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] cols_cfg;
        logic [CFG_W-1:0] rows_cfg;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        in_valid    <= 1'b0;
        func        <= '0;
        filled      <= 1'b0;
        rect_x      <= '0;
        rect_y      <= '0;
        rect_w      <= '0;
        rect_h      <= '0;
        paint_color <= '0;
        read_col    <= '0;
        read_row    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full frame with the reset register values.
        issue_command(FUNC_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0, '0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd0, 8'd0);
        issue_command(FUNC_DRAW, 1'b1, POS_W'(250 * 256 + 128), -POS_W'(512),
                      SIZE_W'(10 * 256), SIZE_W'(3 * 256 + 64), 8'hA5, '0, '0);
        issue_command(FUNC_DRAW, 1'b0, '0, '0, SIZE_W'(255 * 256), SIZE_W'(255 * 256),
                      8'h5A, '0, '0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd255, 8'd255);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd255, 8'd0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd128, 8'd128);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd252, 8'd1);
        issue_command(FUNC_DRAW, 1'b1, 24'h7FFFFF, 24'h800000, '0, 23'h7FFFFF,
                      8'hFF, '0, '0);
        issue_command(FUNC_DRAW, 1'b0, 24'h800000, 24'h7FFFFF, 23'h7FFFFF, '0,
                      8'h00, '0, '0);
        issue_command(FUNC_UNKNOWN, 1'b1, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                      8'hFF, 8'd255, 8'd255);
        finish_phase();

        // Zero width acts as one column, an oversized height as the full height.
        write_reg(CFG_BOARD_WIDTH, '0);
        write_reg(CFG_BOARD_HEIGHT, 9'd511);
        write_reg(CFG_BACKGROUND_COLOR, '0);
        write_reg(CFG_UNUSED, 9'h1FF);
        cfg_we <= 1'b0;
        issue_command(FUNC_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0, '0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd0, 8'd255);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd1, 8'd0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd255, 8'd255);
        finish_phase();

        write_reg(CFG_BOARD_WIDTH, 9'd8);
        write_reg(CFG_BOARD_HEIGHT, 9'd6);
        write_reg(CFG_BACKGROUND_COLOR, 9'd255);
        cfg_we <= 1'b0;
        issue_command(FUNC_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0, '0);
        issue_command(FUNC_DRAW, 1'b1, 24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF,
                      8'h00, '0, '0);
        issue_command(FUNC_DRAW, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                      8'h00, '0, '0);
        issue_command(FUNC_DRAW, 1'b1, -POS_W'(768), -POS_W'(768), 23'h7FFFFF, 23'h7FFFFF,
                      8'h3C, '0, '0);
        issue_command(FUNC_DRAW, 1'b0, POS_W'(456), POS_W'(128), SIZE_W'(768), SIZE_W'(612),
                      8'h00, '0, '0);
        issue_command(FUNC_DRAW, 1'b1, POS_W'(512), POS_W'(512), SIZE_W'(1), SIZE_W'(1),
                      8'hC3, '0, '0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd0, 8'd0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd2, 8'd2);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd7, 8'd5);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd8, 8'd0);
        issue_command(FUNC_READ, 1'b0, '0, '0, '0, '0, '0, 8'd0, 8'd6);
        finish_phase();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    cols_cfg = CFG_W'($urandom_range(2, 16));
                    rows_cfg = CFG_W'($urandom_range(2, 16));
                end
                1:
                begin
                    cols_cfg = CFG_W'($urandom_range(256, 511));
                    rows_cfg = CFG_W'($urandom_range(1, 3));
                end
                2:
                begin
                    cols_cfg = CFG_W'($urandom_range(1, 4));
                    rows_cfg = CFG_W'($urandom_range(256, 300));
                end
                3:
                begin
                    cols_cfg = CFG_W'($urandom_range(1, 24));
                    rows_cfg = CFG_W'($urandom_range(1, 24));
                end
                default:
                begin
                    cols_cfg = CFG_W'($urandom_range(0, 1));
                    rows_cfg = CFG_W'($urandom_range(0, 20));
                end
            endcase
            write_reg(CFG_BOARD_WIDTH, cols_cfg);
            write_reg(CFG_BOARD_HEIGHT, rows_cfg);
            write_reg(CFG_BACKGROUND_COLOR, CFG_W'($urandom_range(0, 255)));
            cfg_we <= 1'b0;
            burst_mode = ($urandom_range(0, 3) == 0);
            // Every pixel in use is written before any read of this phase.
            issue_command(FUNC_CLEAR, 1'($urandom()), POS_W'($urandom()),
                          POS_W'($urandom()), SIZE_W'($urandom()), SIZE_W'($urandom()),
                          COLOR_W'($urandom()), SIDE_W'($urandom()), SIDE_W'($urandom()));
            run_random_items(14);
            finish_phase();
        end

        if (model.errors == 0 && model.pending() == 0)
            $display("rectangle_raster_painter_core regression: pass");
        else
            $display("rectangle_raster_painter_core regression: fail");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        out_stall <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!hold_done && items_taken >= HOLD_AT)
            begin
                // Long hold-off: the result register stays full and the input backs up.
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else if (pick < 70)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else if (pick < 80)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(50, 150)) @(posedge clk);
                end
                else if (pick < 95)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(4, 10)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    // A full-frame walk is the longest stretch with no handshake at all.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("rectangle_raster_painter_core regression: fail");
        $finish;
    end

endmodule

[rectangle_raster_painter_core.f]
+incdir+rtl
rtl/rrp_pkg.sv
rtl/rrp_ram.sv
rtl/rrp_pixel_test.sv
rtl/rectangle_raster_painter_core.sv
tb/sv/tb_canvas_pkg.sv
tb/sv/tb_top.sv
